// ===== rtl/pba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pba_pkg;

  // Class count of the arena; the top level takes it as a parameter.
  localparam int unsigned NUM_CLASSES_DEF = 32;
  // Classes below this one refill their free list with a batch of blocks.
  localparam int unsigned BATCH_CUTOFF    = 12;
  localparam int unsigned HEAP_BYTES      = 65536;

  // One header entry per 8-byte slot of the 16-bit byte space.
  localparam int unsigned HDR_SLOTS = 8192;
  localparam int unsigned HDR_AW    = $clog2(HDR_SLOTS);

  localparam logic [16:0] LIMIT_CAP =
      (HEAP_BYTES > 65536) ? 17'd65536 : 17'(HEAP_BYTES);
  localparam logic [15:0] HDR_BYTES = 16'd16;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_RESIZE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NULL  = 2'd1,
    ST_FAULT = 2'd2
  } status_e;

  typedef enum logic {
    REG_HEAP_BASE  = 1'b0,
    REG_HEAP_LIMIT = 1'b1
  } reg_e;

  typedef struct packed {
    logic        alloc;
    logic [4:0]  cls;
    logic [15:0] next;
  } hdr_t;

  localparam int unsigned HDR_W = $bits(hdr_t);

  // Smallest c >= 1 with size <= 2^c; 32 when size exceeds 2^31.
  function automatic logic [5:0] raw_class(logic [31:0] size);
    logic [31:0] m;
    logic [5:0]  n;
    m = size - 32'd1;
    n = 6'd1;
    if (size > 32'd2) begin
      for (int i = 0; i < 32; i++) begin
        if (m[i]) n = 6'(i + 1);
      end
    end
    return n;
  endfunction

  // Header plus data, rounded up to 8 bytes; valid for classes up to 16.
  function automatic logic [16:0] block_size(logic [4:0] pow);
    logic [16:0] b;
    if (pow < 5'd3) b = 17'd24;
    else if (pow > 5'd16) b = '0;
    else b = 17'd16 + (17'd1 << pow);
    return b;
  endfunction

  function automatic logic [5:0] batch_count(logic [4:0] pow);
    logic [5:0] n;
    if (32'(pow) < BATCH_CUTOFF) n = 6'(BATCH_CUTOFF + 2 - 32'(pow));
    else n = 6'd1;
    return n;
  endfunction

  function automatic logic [16:0] eff_base(logic [15:0] v);
    logic [16:0] b;
    b = {1'b0, v[15:3], 3'b000};
    if (b < 17'd8) b = 17'd8;
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pba_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pba_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/pow2_bucket_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Power-of-two class allocator over a 16-bit byte arena. Pulse start with a command
// (allocate, free, resize) while busy is low; exactly one result follows as a one-cycle
// done_o strobe, and the receiver cannot stall it, so capture the result ports in that
// cycle. After reset the block sweeps its 8192-entry header memory to zero, one entry a
// cycle, and holds busy high until the sweep is done; configuration writes are taken
// meanwhile. A null free, a bad pointer, a fitting resize, a too-large request and a bad
// header end the command without touching the free lists. A refill from the break
// pointer writes one header per cycle through the single write port of the header
// memory, and a moving resize also checks its old header and releases its old block.
// busy drops in the strobe cycle, so the next transfer can share that cycle. Pops and
// releases are read-modify-writes on memories with a registered read port, done
// strictly in sequence.
module pow2_bucket_allocator #(
  parameter int unsigned NUM_CLASSES = pba_pkg::NUM_CLASSES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [31:0] request_size_i,
  input  wire logic [15:0] block_ptr_i,
  // result channel
  output logic             done_o,
  output logic [15:0]      result_addr_o,
  output logic [15:0]      copy_src_o,
  output logic [15:0]      copy_len_o,
  output logic [1:0]       status_o,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  import pba_pkg::*;

  localparam int unsigned CW  = $clog2(NUM_CLASSES);
  localparam logic [5:0]  NC6 = 6'(NUM_CLASSES);

  typedef enum logic [10:0] {
    S_CLEAR   = 11'b000_0000_0001,
    S_IDLE    = 11'b000_0000_0010,
    S_DECODE  = 11'b000_0000_0100,
    S_CHECK   = 11'b000_0000_1000,
    S_ALLOC   = 11'b000_0001_0000,
    S_POP     = 11'b000_0010_0000,
    S_POP_CHK = 11'b000_0100_0000,
    S_CARVE   = 11'b000_1000_0000,
    S_LINK    = 11'b001_0000_0000,
    S_REL_RD  = 11'b010_0000_0000,
    S_REL_WR  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [HDR_AW-1:0] clr_q, clr_d;
  logic [15:0]       base_q, base_d;
  logic [16:0]       limit_q, limit_d;
  logic [16:0]       brk_q, brk_d;

  cmd_e              cmd_q, cmd_d;
  logic [31:0]       size_q, size_d;
  logic [15:0]       ptr_q, ptr_d;
  logic [5:0]        cls_q, cls_d;     // requested class, 32 when too large
  logic [4:0]        cold_q, cold_d;   // class of the block named by the pointer
  logic [15:0]       hdr_q, hdr_d;     // header address of that block
  logic [15:0]       pop_q, pop_d;
  logic [16:0]       bsize_q, bsize_d;
  logic [5:0]        cnt_q, cnt_d;
  logic              big_q, big_d;
  logic [22:0]       total_q, total_d;
  logic [16:0]       cur_q, cur_d;
  logic [5:0]        left_q, left_d;

  logic [15:0]       addr_q, addr_d;
  logic [15:0]       src_q, src_d;
  logic [15:0]       len_q, len_d;
  status_e           stat_q, stat_d;
  logic              done_q, done_d;

  // Free-list heads: memory plus one valid bit per class, so reset empties all lists.
  logic [NUM_CLASSES-1:0] head_vld_q;
  logic                   head_rvld_q;
  logic                   head_we;
  logic [CW-1:0]          head_waddr, head_raddr;
  logic [15:0]            head_wdata, head_rdata, head_val;

  logic                   hdr_we;
  logic [HDR_AW-1:0]      hdr_waddr, hdr_raddr;
  hdr_t                   hdr_wdata;
  logic [HDR_W-1:0]       hdr_rdata;
  hdr_t                   hdr_e;

  logic [16:0]            limit_eff;
  logic [15:0]            ptr_hdr;
  logic                   bad_ptr;
  logic [23:0]            need;
  logic [16:0]            nxt;
  logic                   alloc_ok;
  logic                   move;
  logic                   cfg_wr;

  pba_ram #(
    .WIDTH(16),
    .DEPTH(NUM_CLASSES)
  ) u_heads (
    .clk_i  (clk_i),
    .we_i   (head_we),
    .waddr_i(head_waddr),
    .wdata_i(head_wdata),
    .raddr_i(head_raddr),
    .rdata_o(head_rdata)
  );

  pba_ram #(
    .WIDTH(HDR_W),
    .DEPTH(HDR_SLOTS)
  ) u_hdrs (
    .clk_i  (clk_i),
    .we_i   (hdr_we),
    .waddr_i(hdr_waddr),
    .wdata_i(hdr_wdata),
    .raddr_i(hdr_raddr),
    .rdata_o(hdr_rdata)
  );

  assign head_val  = head_rvld_q ? head_rdata : 16'd0;
  assign hdr_e     = hdr_t'(hdr_rdata);
  assign limit_eff = (limit_q > LIMIT_CAP) ? LIMIT_CAP : limit_q;
  assign ptr_hdr   = ptr_q - HDR_BYTES;
  // A pointer at or below the first header slot, or off the 8-byte grid, is a fault.
  assign bad_ptr   = (ptr_q <= HDR_BYTES) || (ptr_q[2:0] != 3'd0);
  assign need      = {7'd0, brk_q} + {1'b0, total_q};
  assign nxt       = cur_q + bsize_q;
  assign move      = (cmd_q == CMD_RESIZE) && (ptr_q != 16'd0);

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    unique case (reg_e'(paddr[2]))
      REG_HEAP_BASE:  prdata = {16'd0, base_q};
      REG_HEAP_LIMIT: prdata = {15'd0, limit_q};
      default:        prdata = '0;
    endcase
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign result_addr_o = addr_q;
  assign copy_src_o    = src_q;
  assign copy_len_o    = len_q;
  assign status_o      = stat_q;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    base_d  = base_q;
    limit_d = limit_q;
    brk_d   = brk_q;
    cmd_d   = cmd_q;
    size_d  = size_q;
    ptr_d   = ptr_q;
    cls_d   = cls_q;
    cold_d  = cold_q;
    hdr_d   = hdr_q;
    pop_d   = pop_q;
    bsize_d = bsize_q;
    cnt_d   = cnt_q;
    big_d   = big_q;
    total_d = total_q;
    cur_d   = cur_q;
    left_d  = left_q;
    addr_d  = addr_q;
    src_d   = src_q;
    len_d   = len_q;
    stat_d  = stat_q;
    done_d  = 1'b0;
    alloc_ok = 1'b0;

    head_we    = 1'b0;
    head_waddr = cls_q[CW-1:0];
    head_wdata = 16'd0;
    head_raddr = cls_q[CW-1:0];
    hdr_we     = 1'b0;
    hdr_waddr  = clr_q;
    hdr_wdata  = '0;
    hdr_raddr  = ptr_hdr[15:3];

    unique case (state_q)
      S_CLEAR: begin
        // Zero one header entry a cycle.
        hdr_we    = 1'b1;
        hdr_waddr = clr_q;
        clr_d     = clr_q + HDR_AW'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          cmd_d   = cmd_e'(cmd_i);
          size_d  = request_size_i;
          ptr_d   = block_ptr_i;
          addr_d  = '0;
          src_d   = '0;
          len_d   = '0;
          stat_d  = ST_OK;
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        cls_d = raw_class(size_q);
        hdr_d = ptr_hdr;
        // Header read of the named block is issued here for free and resize.
        hdr_raddr = ptr_hdr[15:3];
        case (cmd_q)
          CMD_ALLOC: state_d = S_ALLOC;
          CMD_FREE: begin
            if (ptr_q == 16'd0) begin
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else if (bad_ptr) begin
              stat_d  = ST_FAULT;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              state_d = S_CHECK;
            end
          end
          CMD_RESIZE: begin
            if (ptr_q == 16'd0) begin
              state_d = S_ALLOC;
            end else if (bad_ptr) begin
              stat_d  = ST_FAULT;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              state_d = S_CHECK;
            end
          end
          default: begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end

      S_CHECK: begin
        cold_d = hdr_e.cls;
        if (!hdr_e.alloc || (hdr_e.cls == 5'd0) || ({1'b0, hdr_e.cls} >= NC6)) begin
          stat_d  = ST_FAULT;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (cmd_q == CMD_FREE) begin
          state_d = S_REL_RD;
        end else if (cls_q <= {1'b0, hdr_e.cls}) begin
          // Block is already large enough: hand back the same pointer.
          addr_d  = ptr_q;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_ALLOC;
        end
      end

      S_ALLOC: begin
        if (cls_q >= NC6) begin
          stat_d  = ST_NULL;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          head_raddr = cls_q[CW-1:0];
          bsize_d    = block_size(cls_q[4:0]);
          cnt_d      = batch_count(cls_q[4:0]);
          big_d      = (cls_q > 6'd16);
          state_d    = S_POP;
        end
      end

      S_POP: begin
        total_d   = 23'(bsize_q) * 23'(cnt_q);
        pop_d     = head_val;
        hdr_raddr = head_val[15:3];
        if (head_val != 16'd0) begin
          state_d = S_POP_CHK;
        end else begin
          state_d = S_CARVE;
        end
      end

      S_POP_CHK: begin
        if (hdr_e.alloc) begin
          // Head of a free list marked allocated: corrupt list, leave it as is.
          stat_d  = ST_FAULT;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          head_we         = 1'b1;
          head_waddr      = cls_q[CW-1:0];
          head_wdata      = hdr_e.next;
          hdr_we          = 1'b1;
          hdr_waddr       = pop_q[15:3];
          hdr_wdata       = hdr_e;
          hdr_wdata.alloc = 1'b1;
          addr_d          = pop_q + HDR_BYTES;
          alloc_ok        = 1'b1;
        end
      end

      S_CARVE: begin
        if (big_q || (need > {7'd0, limit_eff})) begin
          stat_d  = ST_NULL;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          // First block goes out allocated; the rest of the batch is linked next.
          hdr_we          = 1'b1;
          hdr_waddr       = brk_q[15:3];
          hdr_wdata.alloc = 1'b1;
          hdr_wdata.cls   = cls_q[4:0];
          hdr_wdata.next  = 16'd0;
          brk_d           = need[16:0];
          addr_d          = brk_q[15:0] + HDR_BYTES;
          cur_d           = brk_q + bsize_q;
          left_d          = cnt_q - 6'd1;
          if (cnt_q > 6'd1) begin
            head_we    = 1'b1;
            head_waddr = cls_q[CW-1:0];
            head_wdata = 16'(brk_q + bsize_q);
            state_d    = S_LINK;
          end else begin
            alloc_ok = 1'b1;
          end
        end
      end

      S_LINK: begin
        hdr_we          = 1'b1;
        hdr_waddr       = cur_q[15:3];
        hdr_wdata.alloc = 1'b0;
        hdr_wdata.cls   = cls_q[4:0];
        hdr_wdata.next  = (left_q == 6'd1) ? 16'd0 : nxt[15:0];
        cur_d           = nxt;
        left_d          = left_q - 6'd1;
        if (left_q == 6'd1) begin
          alloc_ok = 1'b1;
        end
      end

      S_REL_RD: begin
        head_raddr = cold_q[CW-1:0];
        state_d    = S_REL_WR;
      end

      S_REL_WR: begin
        // Push the block onto its class list.
        hdr_we          = 1'b1;
        hdr_waddr       = hdr_q[15:3];
        hdr_wdata.alloc = 1'b0;
        hdr_wdata.cls   = cold_q;
        hdr_wdata.next  = head_val;
        head_we         = 1'b1;
        head_waddr      = cold_q[CW-1:0];
        head_wdata      = hdr_q;
        done_d          = 1'b1;
        state_d         = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase

    // A moving resize releases the old block only after the new one is secured.
    if (alloc_ok) begin
      if (move) begin
        src_d   = ptr_q;
        len_d   = cold_q[4] ? 16'd0 : (16'd1 << cold_q[3:0]);
        state_d = S_REL_RD;
      end else begin
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
    end

    if (cfg_wr) begin
      unique case (reg_e'(paddr[2]))
        REG_HEAP_BASE: begin
          base_d = pwdata[15:0];
          brk_d  = eff_base(pwdata[15:0]);
        end
        REG_HEAP_LIMIT: limit_d = pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      base_q     <= 16'd16;
      limit_q    <= 17'd65536;
      brk_q      <= 17'd16;
      done_q     <= 1'b0;
      head_vld_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      base_q  <= base_d;
      limit_q <= limit_d;
      brk_q   <= brk_d;
      done_q  <= done_d;
      if (head_we) begin
        head_vld_q[head_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    head_rvld_q <= head_vld_q[head_raddr];
    cmd_q       <= cmd_d;
    size_q      <= size_d;
    ptr_q       <= ptr_d;
    cls_q       <= cls_d;
    cold_q      <= cold_d;
    hdr_q       <= hdr_d;
    pop_q       <= pop_d;
    bsize_q     <= bsize_d;
    cnt_q       <= cnt_d;
    big_q       <= big_d;
    total_q     <= total_d;
    cur_q       <= cur_d;
    left_q      <= left_d;
    addr_q      <= addr_d;
    src_q       <= src_d;
    len_q       <= len_d;
    stat_q      <= stat_d;
  end

endmodule

`default_nettype wire
